[rtl/core/srgb8_pkg.sv]
// Shared constants and the sRGB curve entry function for the resolve core.
package srgb8_pkg;

   localparam int unsigned SUM_BITS    = 32;
   localparam int unsigned WEIGHT_BITS = 16;
   localparam int unsigned PIXEL_BITS  = 8;

   localparam real INV_GAMMA = 1.0 / 2.4;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   // Curve entry for index idx with idx_bits fraction bits: 255 * sRGB(idx / 2^idx_bits).
   function automatic pixel_type curve_entry(input int idx, input int idx_bits);
      longint lin_lhs;
      longint lin_rhs;
      longint lin;
      real    c;
      real    v;
      int     iv;
      begin
         lin_lhs = longint'(idx) * 64'sd10000000;
         lin_rhs = 64'sd31308 <<< idx_bits;
         if (lin_lhs <= lin_rhs) begin
            // Count levels up to floor(idx * 32946 / (10 * 2^idx_bits)).
            lin = 0;
            while (lin < 255 &&
                   ((lin + 1) * (64'sd10 <<< idx_bits)) <= (longint'(idx) * 64'sd32946)) begin
               lin++;
            end
            iv = int'(lin);
         end else begin
            c  = real'(idx) * (2.0 ** (-idx_bits));
            v  = 255.0 * (1.055 * (c ** INV_GAMMA) - 0.055);
            iv = $rtoi(v + 1.0e-9);
            if (iv > 255) iv = 255;
            if (iv < 0) iv = 0;
         end
         curve_entry = pixel_type'(iv);
      end
   endfunction

endpackage

[rtl/core/srgb8_lane.sv]
// One color lane: pipelined restoring divider, saturation and curve lookup.
module srgb8_lane #(
   parameter int unsigned CURVE_INDEX_BITS  = 12,
   parameter int unsigned SUM_FRACTION_BITS = 16
) (
   input  logic                                   clock,
   input  logic [srgb8_pkg::SUM_BITS-2+((CURVE_INDEX_BITS > SUM_FRACTION_BITS) ?
                 (CURVE_INDEX_BITS - SUM_FRACTION_BITS) : 0):0] num,
   input  logic [srgb8_pkg::WEIGHT_BITS-1+((SUM_FRACTION_BITS > CURVE_INDEX_BITS) ?
                 (SUM_FRACTION_BITS - CURVE_INDEX_BITS) : 0):0] den,
   output srgb8_pkg::pixel_type                   pixel
);

   localparam int unsigned UP     = (CURVE_INDEX_BITS > SUM_FRACTION_BITS) ?
                                    (CURVE_INDEX_BITS - SUM_FRACTION_BITS) : 0;
   localparam int unsigned DOWN   = (SUM_FRACTION_BITS > CURVE_INDEX_BITS) ?
                                    (SUM_FRACTION_BITS - CURVE_INDEX_BITS) : 0;
   localparam int unsigned NUM_W  = srgb8_pkg::SUM_BITS - 1 + UP;
   localparam int unsigned DEN_W  = srgb8_pkg::WEIGHT_BITS + DOWN;
   localparam int unsigned SH_W   = DEN_W + CURVE_INDEX_BITS + 2;
   localparam int unsigned CW     = (NUM_W > SH_W) ? NUM_W : SH_W;
   localparam int unsigned STAGES = CURVE_INDEX_BITS + 1;
   localparam int unsigned Q_W    = CURVE_INDEX_BITS + 1;
   localparam int unsigned SIZE   = (1 << CURVE_INDEX_BITS) + 1;

   logic [CW-1:0]    rem_ff [STAGES+1];
   logic [CW-1:0]    den_ff [STAGES+1];
   logic [Q_W-1:0]   q_ff   [STAGES+1];
   logic             sat_ff [STAGES+1];
   logic [Q_W-1:0]   index;
   srgb8_pkg::pixel_type curve [SIZE];
   srgb8_pkg::pixel_type pixel_ff;

   // Overflow check: quotient of 2^(N+1) or more saturates.
   always_ff @(posedge clock) begin
      rem_ff[0] <= CW'(num);
      den_ff[0] <= CW'(den);
      q_ff[0]   <= '0;
      sat_ff[0] <= (CW'(num) >= (CW'(den) << (CURVE_INDEX_BITS + 1)));
   end

   for (genvar j = 1; j <= STAGES; j++) begin : g_div
      localparam int unsigned K = STAGES - j;
      logic [CW-1:0] trial;
      logic          fits;
      assign trial = den_ff[j-1] << K;
      assign fits  = rem_ff[j-1] >= trial;
      always_ff @(posedge clock) begin
         rem_ff[j] <= fits ? (rem_ff[j-1] - trial) : rem_ff[j-1];
         den_ff[j] <= den_ff[j-1];
         q_ff[j]   <= q_ff[j-1] | (fits ? (Q_W'(1) << K) : '0);
         sat_ff[j] <= sat_ff[j-1];
      end
   end

   // Clamp the quotient to the last table index.
   always_comb begin
      if (sat_ff[STAGES] || (q_ff[STAGES] > (Q_W'(1) << CURVE_INDEX_BITS))) begin
         index = Q_W'(1) << CURVE_INDEX_BITS;
      end else begin
         index = q_ff[STAGES];
      end
   end

   for (genvar i = 0; i < SIZE; i++) begin : g_rom
      assign curve[i] = srgb8_pkg::curve_entry(i, CURVE_INDEX_BITS);
   end

   always_ff @(posedge clock) begin
      pixel_ff <= curve[index];
   end

   assign pixel = pixel_ff;

endmodule

[rtl/core/resolve_accumulated_to_srgb8_core.sv]
// Top level: sRGB resolve of accumulated pixels, three color lanes side by side.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ------------------------
//   request   req_sum_red/green/blue, req_sample_weight  start & !busy
//   result    rsp_out_red/green/blue                   rsp_valid, one cycle
//
// One pixel is taken every cycle; busy stays low. Each item passes through
// one input stage, one divider stage per quotient bit (CURVE_INDEX_BITS + 1)
// and one curve table read. Reset clears the valid pipeline only; the result
// side cannot stall.
module resolve_accumulated_to_srgb8_core #(
   parameter int unsigned CURVE_INDEX_BITS  = 12,
   parameter int unsigned SUM_FRACTION_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [31:0]   req_sum_red,
   input  logic signed [31:0]   req_sum_green,
   input  logic signed [31:0]   req_sum_blue,
   input  logic [15:0]          req_sample_weight,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_out_red,
   output logic [7:0]           rsp_out_green,
   output logic [7:0]           rsp_out_blue
);

   localparam int unsigned UP    = (CURVE_INDEX_BITS > SUM_FRACTION_BITS) ?
                                   (CURVE_INDEX_BITS - SUM_FRACTION_BITS) : 0;
   localparam int unsigned DOWN  = (SUM_FRACTION_BITS > CURVE_INDEX_BITS) ?
                                   (SUM_FRACTION_BITS - CURVE_INDEX_BITS) : 0;
   localparam int unsigned NUM_W = srgb8_pkg::SUM_BITS - 1 + UP;
   localparam int unsigned DEN_W = srgb8_pkg::WEIGHT_BITS + DOWN;
   localparam int unsigned LAT   = CURVE_INDEX_BITS + 3;

   logic [NUM_W-1:0] num_red;
   logic [NUM_W-1:0] num_green;
   logic [NUM_W-1:0] num_blue;
   logic [DEN_W-1:0] den;
   logic [15:0]      weight;
   logic [LAT-1:0]   valid_ff;
   logic [LAT-1:0]   valid_in;

   assign busy = 1'b0;

   // Drop sign: negative sums give index zero.
   assign num_red   = req_sum_red[31]   ? '0 : (NUM_W'(req_sum_red[30:0]) << UP);
   assign num_green = req_sum_green[31] ? '0 : (NUM_W'(req_sum_green[30:0]) << UP);
   assign num_blue  = req_sum_blue[31]  ? '0 : (NUM_W'(req_sum_blue[30:0]) << UP);
   assign weight    = (req_sample_weight == 16'd0) ? 16'd1 : req_sample_weight;
   assign den       = DEN_W'(weight) << DOWN;

   assign valid_in = {valid_ff[LAT-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   srgb8_lane #(
      .CURVE_INDEX_BITS (CURVE_INDEX_BITS),
      .SUM_FRACTION_BITS(SUM_FRACTION_BITS)
   ) u_lane_red (
      .clock(clock),
      .num  (num_red),
      .den  (den),
      .pixel(rsp_out_red)
   );

   srgb8_lane #(
      .CURVE_INDEX_BITS (CURVE_INDEX_BITS),
      .SUM_FRACTION_BITS(SUM_FRACTION_BITS)
   ) u_lane_green (
      .clock(clock),
      .num  (num_green),
      .den  (den),
      .pixel(rsp_out_green)
   );

   srgb8_lane #(
      .CURVE_INDEX_BITS (CURVE_INDEX_BITS),
      .SUM_FRACTION_BITS(SUM_FRACTION_BITS)
   ) u_lane_blue (
      .clock(clock),
      .num  (num_blue),
      .den  (den),
      .pixel(rsp_out_blue)
   );

   assign rsp_valid = valid_ff[LAT-1];

endmodule

[dv/testbench.sv]
// Self-checking testbench for the accumulated-pixel sRGB resolve core.
module testbench;

   localparam int unsigned IDX_BITS  = 12;
   localparam int unsigned FRAC_BITS = 16;
   localparam int unsigned LAST_IDX  = 1 << IDX_BITS;
   localparam int unsigned LATENCY   = IDX_BITS + 3;

   typedef struct {
      logic signed [srgb8_pkg::SUM_BITS-1:0]  red;
      logic signed [srgb8_pkg::SUM_BITS-1:0]  green;
      logic signed [srgb8_pkg::SUM_BITS-1:0]  blue;
      logic [srgb8_pkg::WEIGHT_BITS-1:0]      weight;
   } pixel_item_type;

   typedef struct {
      srgb8_pkg::pixel_type red;
      srgb8_pkg::pixel_type green;
      srgb8_pkg::pixel_type blue;
   } srgb_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_sum_red = '0;
   logic signed [31:0] req_sum_green = '0;
   logic signed [31:0] req_sum_blue = '0;
   logic [15:0] req_sample_weight = '0;
   logic rsp_valid;
   logic [7:0] rsp_out_red;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_blue;

   pixel_item_type pending_pixels[$];
   srgb_pixel_type expected_srgb[$];
   srgb8_pkg::pixel_type srgb_curve[LAST_IDX+1];
   bit no_gaps = 1'b0;
   int unsigned error_count = 0;
   int unsigned accepted_count = 0;
   int unsigned checked_count = 0;
   int unsigned zero_weight_count = 0;

   resolve_accumulated_to_srgb8_core #(
      .CURVE_INDEX_BITS(IDX_BITS),
      .SUM_FRACTION_BITS(FRAC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_sum_red(req_sum_red),
      .req_sum_green(req_sum_green),
      .req_sum_blue(req_sum_blue),
      .req_sample_weight(req_sample_weight),
      .rsp_valid(rsp_valid),
      .rsp_out_red(rsp_out_red),
      .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue)
   );

   always #4 clock = ~clock;

   // Exact table: power segment compares i^5 * 269025^12 against
   // (1000 v + 14025)^12 * 2^(5 IDX_BITS), all in wide integers.
   function automatic void build_srgb_curve();
      bit [383:0] base;
      bit [383:0] prod;
      bit [383:0] bound[256];
      int unsigned lvl;
      base = 1;
      for (int k = 0; k < 12; k++) base = base * 384'd269025;
      for (int v = 0; v < 256; v++) begin
         bound[v] = 1;
         for (int k = 0; k < 12; k++) bound[v] = bound[v] * (384'(1000 * v + 14025));
         for (int k = 0; k < 5; k++) bound[v] = bound[v] << IDX_BITS;
      end
      lvl = 0;
      for (int i = 0; i <= LAST_IDX; i++) begin
         if (longint'(i) * 10000000 <= (longint'(31308) << IDX_BITS)) begin
            longint lin;
            lin = (longint'(i) * 32946) / (longint'(10) << IDX_BITS);
            srgb_curve[i] = (lin > 255) ? 8'd255 : srgb8_pkg::pixel_type'(lin);
         end else begin
            prod = base;
            for (int k = 0; k < 5; k++) prod = prod * 384'(i);
            while (lvl < 255 && prod >= bound[lvl+1]) lvl++;
            srgb_curve[i] = srgb8_pkg::pixel_type'(lvl);
         end
      end
   endfunction

   function automatic int unsigned curve_index_of(logic signed [31:0] sum,
                                                  longint weight);
      longint q;
      if (sum <= 0) return 0;
      q = longint'(sum) / (weight << (FRAC_BITS - IDX_BITS));
      return (q > LAST_IDX) ? LAST_IDX : int'(q);
   endfunction

   function automatic srgb_pixel_type resolve_pixel(pixel_item_type px);
      srgb_pixel_type res;
      longint w;
      w = (px.weight == 0) ? 1 : longint'(px.weight);
      res.red   = srgb_curve[curve_index_of(px.red, w)];
      res.green = srgb_curve[curve_index_of(px.green, w)];
      res.blue  = srgb_curve[curve_index_of(px.blue, w)];
      return res;
   endfunction

   // Driver: hold the item while not taken, otherwise advance or idle.
   always @(posedge clock) begin
      pixel_item_type px;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            px.red = req_sum_red;
            px.green = req_sum_green;
            px.blue = req_sum_blue;
            px.weight = req_sample_weight;
            expected_srgb.push_back(resolve_pixel(px));
            accepted_count++;
            if (px.weight == 0) zero_weight_count++;
         end
         if (!(start && busy)) begin
            if (pending_pixels.size() > 0 && (no_gaps || $urandom_range(99) >= 6)) begin
               px = pending_pixels.pop_front();
               start <= 1'b1;
               req_sum_red <= px.red;
               req_sum_green <= px.green;
               req_sum_blue <= px.blue;
               req_sample_weight <= px.weight;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result must match the oldest expectation.
   always @(posedge clock) begin
      srgb_pixel_type exp_px;
      if (!reset && rsp_valid) begin
         if (expected_srgb.size() == 0) begin
            $error("unexpected result %0d/%0d/%0d", rsp_out_red, rsp_out_green,
                   rsp_out_blue);
            error_count++;
         end else begin
            exp_px = expected_srgb.pop_front();
            checked_count++;
            if (rsp_out_red !== exp_px.red) begin
               $error("out_red expected %0d actual %0d", exp_px.red, rsp_out_red);
               error_count++;
            end
            if (rsp_out_green !== exp_px.green) begin
               $error("out_green expected %0d actual %0d", exp_px.green, rsp_out_green);
               error_count++;
            end
            if (rsp_out_blue !== exp_px.blue) begin
               $error("out_blue expected %0d actual %0d", exp_px.blue, rsp_out_blue);
               error_count++;
            end
         end
      end
   end

   function automatic pixel_item_type make_pixel(longint r, longint g, longint b, int w);
      pixel_item_type px;
      px.red = r[31:0];
      px.green = g[31:0];
      px.blue = b[31:0];
      px.weight = w[15:0];
      return px;
   endfunction

   // Sum that lands near a chosen curve index for the given weight.
   function automatic longint sum_near_index(int unsigned w);
      longint ww;
      longint s;
      ww = (w == 0) ? 1 : w;
      s = longint'($urandom_range(LAST_IDX + 100)) * ww * (1 << (FRAC_BITS - IDX_BITS))
          + longint'($urandom_range(32'(ww * 16 - 1)));
      return (s > 64'sd2147483647) ? 64'sd2147483647 : s;
   endfunction

   function automatic longint random_sum(int unsigned w);
      case ($urandom_range(9))
         0: return longint'($signed($urandom()));
         1: return -longint'($urandom_range(1000));
         2: return 0;
         default: return sum_near_index(w);
      endcase
   endfunction

   function automatic int unsigned random_weight();
      case ($urandom_range(9))
         0: return 0;
         1: return 1;
         2: return $urandom_range(65535);
         3: return 65535;
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   initial begin
      int unsigned w;
      build_srgb_curve();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, zero weight, clamping, saturation, segment edge.
      pending_pixels.push_back(make_pixel(0, 0, 0, 0));
      pending_pixels.push_back(make_pixel(64'sd2147483647, -64'sd2147483648, 1, 0));
      pending_pixels.push_back(make_pixel(-1, 64'sd2147483647, 65536, 65535));
      pending_pixels.push_back(make_pixel(65536, 65537, 65535, 1));
      pending_pixels.push_back(make_pixel(12 * 16, 13 * 16, 11 * 16, 1));
      pending_pixels.push_back(make_pixel(12 * 16 + 15, 13 * 16 - 1, 1, 1));
      pending_pixels.push_back(make_pixel(64'sd65535 << 16, (64'sd65535 << 16) - 1,
                                          32768 * 65535, 65535));
      pending_pixels.push_back(make_pixel(131072, 131071, 65536, 2));
      pending_pixels.push_back(make_pixel(16, 32, 4096 * 16 - 1, 0));
      pending_pixels.push_back(make_pixel(-64'sd2147483648, 0, -1, 65535));
      pending_pixels.push_back(make_pixel(32'h5555_5555, 32'h2aaa_aaaa, 32'h7fff_0000, 16'haaaa));
      pending_pixels.push_back(make_pixel(32'h0000_ffff, 32'h0001_0000, 32'h0000_8000, 16'h5555));

      // Pause the sender until everything in flight has been checked.
      wait (pending_pixels.size() == 0 && !start);
      wait (expected_srgb.size() == 0);

      for (int n = 0; n < 750; n++) begin
         w = random_weight();
         pending_pixels.push_back(make_pixel(random_sum(w), random_sum(w), random_sum(w), w));
         if (n == 300) no_gaps = 1'b1;
         if (n == 450) no_gaps = 1'b0;
         if (n % 50 == 49) wait (pending_pixels.size() < 20);
      end

      wait (pending_pixels.size() == 0 && !start);
      wait (expected_srgb.size() == 0);
      repeat (LATENCY * 2) @(posedge clock);
      $display("Resolved %0d pixels (%0d with zero weight), %0d results checked.",
               accepted_count, zero_weight_count, checked_count);
      if (error_count == 0 && expected_srgb.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d results outstanding", expected_srgb.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
